>>> rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |-> (b)) \
        else $error("implication check failed");

// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (a) |=> (b)) \
        else $error("next-cycle check failed");

`endif

>>> rtl/cms_pkg.sv
// ----------------------------------------------------------------------------
// cms_pkg
// Shared types and constants of the credited message serializer.
// ----------------------------------------------------------------------------
`default_nettype none

package cms_pkg;

    // default parameter values
    localparam int MSG_BITS_DEF  = 128;
    localparam int BEAT_BITS_DEF = 32;
    localparam int CREDITS_DEF   = 32;

    // fixed field widths
    localparam int WORD_W       = 64;
    localparam int SHIFT_W      = 2 * WORD_W;
    localparam int BEAT_DATA_W  = 32;
    localparam int CRED_OUT_W   = 6;

    // stream packing
    localparam int S_FIELDS_W   = 1 + WORD_W + WORD_W + 1;
    localparam int S_TDATA_W    = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int S_TUSER_W    = 1;
    localparam int M_TDATA_W    = 1 + 1 + BEAT_DATA_W + CRED_OUT_W;

    // bit positions on the result tdata
    localparam int M_ACCEPT_BIT = 0;
    localparam int M_BEAT_BIT   = 1;

    typedef struct packed {
        logic                    accept_ready;
        logic                    beat_valid;
        logic [BEAT_DATA_W-1:0]  beat_data;
        logic                    beat_last;
        logic [CRED_OUT_W-1:0]   credits_left;
    } result_t;

endpackage

`default_nettype wire

>>> rtl/credited_message_serializer.sv
// results are registered in the output register or skid entry before m_tdata
// throughput: one input per cycle while s_tready is high, one result per input
// the serializer state updates in the same cycle the input is accepted
// a two-entry output buffer keeps s_tready high while one result waits
// reset: synchronous active-low, credits reload to CREDITS, shift register clears
// ----------------------------------------------------------------------------
// credited_message_serializer
// Shifts a wide message out in beats, gated by a saturating credit counter.
// ----------------------------------------------------------------------------
`default_nettype none

module credited_message_serializer #(
    parameter int MSG_BITS  = cms_pkg::MSG_BITS_DEF,
    parameter int BEAT_BITS = cms_pkg::BEAT_BITS_DEF,
    parameter int CREDITS   = cms_pkg::CREDITS_DEF
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // msg_valid, msg_low, msg_high, credit_return, zero fill
    input  wire logic [cms_pkg::S_TDATA_W-1:0] s_tdata,
    // msg_is_completion
    input  wire logic [cms_pkg::S_TUSER_W-1:0] s_tuser,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // accept_ready, beat_valid, beat_data, credits_left
    output logic [cms_pkg::M_TDATA_W-1:0]      m_tdata,
    output logic                               m_tlast
);
    import cms_pkg::*;

    localparam int NUM_BEATS = (MSG_BITS - 1) / BEAT_BITS + 1;
    localparam int IDX_W     = (NUM_BEATS > 1) ? $clog2(NUM_BEATS) : 1;
    localparam int CNT_W     = $clog2(CREDITS + 1);
    localparam int BEAT_KEEP = (BEAT_BITS < BEAT_DATA_W) ? BEAT_BITS : BEAT_DATA_W;

    localparam logic [IDX_W-1:0]       LAST_IDX  = IDX_W'(NUM_BEATS - 1);
    localparam logic [CNT_W-1:0]       CRED_MAX  = CNT_W'(CREDITS);
    localparam logic [SHIFT_W-1:0]     MSG_MASK  = {SHIFT_W{1'b1}} >> (SHIFT_W - MSG_BITS);
    localparam logic [BEAT_DATA_W-1:0] BEAT_MASK =
        {BEAT_DATA_W{1'b1}} >> (BEAT_DATA_W - BEAT_KEEP);

    // input fields
    logic                 msg_valid;
    logic [WORD_W-1:0]    msg_low;
    logic [WORD_W-1:0]    msg_high;
    logic                 credit_return;
    logic                 msg_is_completion;

    assign msg_valid         = s_tdata[0];
    assign msg_low           = s_tdata[WORD_W:1];
    assign msg_high          = s_tdata[2*WORD_W:WORD_W+1];
    assign credit_return     = s_tdata[2*WORD_W+1];
    assign msg_is_completion = s_tuser[0];

    // serializer state
    logic [SHIFT_W-1:0] shift_reg, shift_next;
    logic               busy_reg, busy_next;
    logic               held_cpl_reg, held_cpl_next;
    logic [IDX_W-1:0]   beat_idx_reg, beat_idx_next;
    logic [CNT_W-1:0]   credit_reg, credit_next;

    // output buffer
    result_t out_data_reg, out_data_next;
    logic    out_valid_reg, out_valid_next;
    result_t skid_data_reg, skid_data_next;
    logic    skid_valid_reg, skid_valid_next;

    logic                   in_xact;
    logic                   take;
    logic                   beat_valid;
    logic                   beat_last;
    logic                   consume;
    logic [CNT_W+CRED_OUT_W-1:0] credit_wide;
    result_t                res;

    assign s_tready = !skid_valid_reg;
    assign in_xact  = s_tvalid && s_tready;

    assign take       = msg_valid && !busy_reg && (msg_is_completion || credit_reg != '0);
    assign beat_valid = busy_reg && (credit_reg != '0 || held_cpl_reg);
    assign beat_last  = beat_valid && (beat_idx_reg >= LAST_IDX);
    assign consume    = beat_valid && !take && beat_last && !held_cpl_reg;
    assign credit_wide = {{CRED_OUT_W{1'b0}}, credit_reg};

    always_comb begin
        res.accept_ready = take;
        res.beat_valid   = beat_valid;
        res.beat_data    = shift_reg[BEAT_DATA_W-1:0] & BEAT_MASK;
        res.beat_last    = beat_last;
        res.credits_left = credit_wide[CRED_OUT_W-1:0];
    end

    // serializer next state, advanced once per input transaction
    always_comb begin
        shift_next    = shift_reg;
        busy_next     = busy_reg;
        held_cpl_next = held_cpl_reg;
        beat_idx_next = beat_idx_reg;
        credit_next   = credit_reg;
        if (in_xact) begin
            if (take) begin
                shift_next    = {msg_high, msg_low} & MSG_MASK;
                busy_next     = 1'b1;
                held_cpl_next = msg_is_completion;
                beat_idx_next = '0;
            end else if (beat_valid) begin
                shift_next = shift_reg >> BEAT_BITS;
                if (beat_last) begin
                    busy_next     = 1'b0;
                    beat_idx_next = '0;
                end else begin
                    beat_idx_next = beat_idx_reg + 1'b1;
                end
            end
            // a return and a consume in the same transaction cancel
            if (consume && !credit_return) begin
                if (credit_reg != '0) begin
                    credit_next = credit_reg - 1'b1;
                end
            end else if (credit_return && !consume) begin
                if (credit_reg < CRED_MAX) begin
                    credit_next = credit_reg + 1'b1;
                end
            end
        end
    end

    // output register with skid entry
    always_comb begin
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg;
        skid_data_next  = skid_data_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end else if (in_xact) begin
                out_data_next  = res;
                out_valid_next = 1'b1;
            end else begin
                out_valid_next = 1'b0;
            end
        end else if (in_xact) begin
            skid_data_next  = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg      <= '0;
            busy_reg       <= 1'b0;
            held_cpl_reg   <= 1'b0;
            beat_idx_reg   <= '0;
            credit_reg     <= CRED_MAX;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            shift_reg      <= shift_next;
            busy_reg       <= busy_next;
            held_cpl_reg   <= held_cpl_next;
            beat_idx_reg   <= beat_idx_next;
            credit_reg     <= credit_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_data_reg.beat_last;
    assign m_tdata  = {out_data_reg.credits_left, out_data_reg.beat_data,
                       out_data_reg.beat_valid, out_data_reg.accept_ready};

endmodule

`default_nettype wire

>>> rtl/cms_checker.sv
// ----------------------------------------------------------------------------
// cms_checker
// Port-level checks of the credited message serializer.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module cms_checker (
    input wire logic                          aclk,
    input wire logic                          aresetn,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [cms_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic                          m_tlast
);
    import cms_pkg::*;

    // a last beat is always a driven beat
    `ASSERT_IMPLY(a_last_is_beat, aclk, aresetn, m_tvalid && m_tlast, m_tdata[M_BEAT_BIT])

    // a message is never taken in a tick that also sends a beat
    `ASSERT_IMPLY(a_take_not_beat, aclk, aresetn, m_tvalid && m_tdata[M_ACCEPT_BIT],
                  !m_tdata[M_BEAT_BIT])

    // a stalled result holds
    `ASSERT_NEXT(a_stall_hold, aclk, aresetn, m_tvalid && !m_tready,
                 m_tvalid && $stable(m_tdata) && $stable(m_tlast))

    // an input transaction always leaves a result waiting in the next cycle
    `ASSERT_NEXT(a_xact_to_result, aclk, aresetn, s_tvalid && s_tready, m_tvalid)

    // reset leaves the output empty and the input ready
    `ASSERT_NEXT(a_reset_empty, aclk, 1'b1, !aresetn, !m_tvalid && s_tready)

endmodule

bind credited_message_serializer cms_checker u_cms_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Clock-by-clock check of the credited message serializer. Every input
// transaction is one link tick; a local model of the shift register, beat
// counter and credit counter predicts the result of each tick, and every
// result transaction is compared with the oldest prediction. Directed ticks
// cover the field extremes and the credit corner cases; random phases drain
// and refill the credits with random message contents. Both sides idle.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import cms_pkg::*;

    localparam int MSG_BITS  = MSG_BITS_DEF;
    localparam int BEAT_BITS = BEAT_BITS_DEF;
    localparam int CREDITS   = CREDITS_DEF;
    localparam int NUM_BEATS = (MSG_BITS - 1) / BEAT_BITS + 1;

    // s_tdata layout
    localparam int S_VALID_BIT = 0;
    localparam int S_LOW_LSB   = 1;
    localparam int S_HIGH_LSB  = 1 + WORD_W;
    localparam int S_RET_BIT   = 1 + 2 * WORD_W;
    // m_tdata layout
    localparam int M_DATA_LSB  = 2;
    localparam int M_CRED_LSB  = 2 + BEAT_DATA_W;

    localparam logic [SHIFT_W-1:0] MSG_MASK  = {SHIFT_W{1'b1}} >> (SHIFT_W - MSG_BITS);
    localparam logic [SHIFT_W-1:0] BEAT_MASK = {SHIFT_W{1'b1}} >> (SHIFT_W - BEAT_BITS);

    localparam int RAND_PHASES = 10;
    localparam int PHASE_TICKS = 175;

    typedef struct {
        logic              msg_valid;
        logic [WORD_W-1:0] msg_low;
        logic [WORD_W-1:0] msg_high;
        logic              is_completion;
        logic              credit_return;
    } tick_t;

    typedef struct {
        logic                   accept;
        logic                   beat;
        logic [BEAT_DATA_W-1:0] data;
        logic                   last;
        logic [CRED_OUT_W-1:0]  credits;
    } link_out_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic [S_TUSER_W-1:0]  s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;

    credited_message_serializer #(
        .MSG_BITS  (MSG_BITS),
        .BEAT_BITS (BEAT_BITS),
        .CREDITS   (CREDITS)
    ) uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    // low phase first so the first rising edge comes after time zero
    always begin
        aclk = 1'b0;
        #2;
        aclk = 1'b1;
        #2;
    end

    tick_t     tick_pend_q[$];
    link_out_t link_expect_q[$];
    int        errors = 0;
    logic      in_fire = 1'b0;

    // local copy of the serializer state
    logic [SHIFT_W-1:0] ser_shift = '0;
    logic               ser_busy = 1'b0;
    logic               ser_held_completion = 1'b0;
    int                 ser_beat_idx = 0;
    int                 ser_credits = CREDITS;

    function automatic bit chance(int pct);
        return $urandom_range(0, 99) < pct;
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // one link tick of the serializer
    task automatic serialize_tick(input tick_t t, output link_out_t o);
        logic take;
        logic beat;
        logic last;
        logic spend;
        logic [SHIFT_W-1:0] shown;
        shown = ser_shift & BEAT_MASK;
        take = t.msg_valid && !ser_busy && (t.is_completion || ser_credits != 0);
        beat = ser_busy && (ser_credits != 0 || ser_held_completion);
        last = beat && (ser_beat_idx >= NUM_BEATS - 1);
        spend = 1'b0;
        o.accept = take;
        o.beat = beat;
        o.data = shown[BEAT_DATA_W-1:0];
        o.last = last;
        o.credits = ser_credits[CRED_OUT_W-1:0];
        if (take) begin
            ser_shift = {t.msg_high, t.msg_low} & MSG_MASK;
            ser_busy = 1'b1;
            ser_held_completion = t.is_completion;
            ser_beat_idx = 0;
        end else if (beat) begin
            ser_shift = ser_shift >> BEAT_BITS;
            if (last) begin
                ser_busy = 1'b0;
                ser_beat_idx = 0;
                spend = !ser_held_completion;
            end else begin
                ser_beat_idx++;
            end
        end
        // a return in the same tick as a spend cancels it
        if (spend && !t.credit_return) begin
            if (ser_credits != 0) ser_credits--;
        end else if (t.credit_return && !spend) begin
            if (ser_credits < CREDITS) ser_credits++;
        end
    endtask

    task automatic queue_tick(input logic v, input logic [WORD_W-1:0] lo,
                              input logic [WORD_W-1:0] hi, input logic comp, input logic ret);
        tick_t t;
        t.msg_valid = v;
        t.msg_low = lo;
        t.msg_high = hi;
        t.is_completion = comp;
        t.credit_return = ret;
        tick_pend_q.push_back(t);
    endtask

    // sender: bursts of random length separated by random gaps
    int burst_left = 1;
    int gap_left = 0;

    always @(negedge aclk) begin : driver
        tick_t t;
        logic [S_TDATA_W-1:0] v;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= '0;
        end else if (!s_tvalid || in_fire) begin
            if (gap_left != 0 || tick_pend_q.size() == 0) begin
                s_tvalid <= 1'b0;
                if (gap_left != 0) gap_left--;
            end else begin
                t = tick_pend_q.pop_front();
                v = '0;
                v[S_VALID_BIT] = t.msg_valid;
                v[S_LOW_LSB +: WORD_W] = t.msg_low;
                v[S_HIGH_LSB +: WORD_W] = t.msg_high;
                v[S_RET_BIT] = t.credit_return;
                s_tvalid <= 1'b1;
                s_tdata <= v;
                s_tuser <= t.is_completion;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left = chance(30) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end
        end
    end

    // receiver: a new stall mode is drawn at the end of every window
    int rx_mode = 0;
    int rx_window = 50;
    int rx_cyc = 0;

    always @(negedge aclk) begin : receiver
        rx_cyc++;
        if (rx_window <= 0) begin
            rx_mode = $urandom_range(0, 3);
            rx_window = $urandom_range(20, 200);
        end else begin
            rx_window--;
        end
        case (rx_mode)
            0: begin
                m_tready <= 1'b1;
            end
            1: begin
                m_tready <= chance(75);
            end
            2: begin
                m_tready <= chance(25);
            end
            default: begin
                m_tready <= (rx_cyc % 7) < 3;
            end
        endcase
    end

    always @(posedge aclk) begin : monitor
        link_out_t e;
        link_out_t p;
        tick_t t;
        in_fire <= s_tvalid && s_tready;
        if (aresetn) begin
            // check before predicting so a stray result never meets a fresh expectation
            if (m_tvalid && m_tready) begin
                if (link_expect_q.size() == 0) begin
                    $error("result transaction with nothing expected: %h", m_tdata);
                    errors++;
                end else begin
                    e = link_expect_q.pop_front();
                    if (m_tdata[M_ACCEPT_BIT] !== e.accept) begin
                        $error("accept_ready: expected %b, actual %b",
                               e.accept, m_tdata[M_ACCEPT_BIT]);
                        errors++;
                    end
                    if (m_tdata[M_BEAT_BIT] !== e.beat) begin
                        $error("beat_valid: expected %b, actual %b", e.beat, m_tdata[M_BEAT_BIT]);
                        errors++;
                    end
                    if (m_tdata[M_DATA_LSB +: BEAT_DATA_W] !== e.data) begin
                        $error("beat_data: expected %h, actual %h",
                               e.data, m_tdata[M_DATA_LSB +: BEAT_DATA_W]);
                        errors++;
                    end
                    if (m_tlast !== e.last) begin
                        $error("beat_last: expected %b, actual %b", e.last, m_tlast);
                        errors++;
                    end
                    if (m_tdata[M_CRED_LSB +: CRED_OUT_W] !== e.credits) begin
                        $error("credits_left: expected %0d, actual %0d",
                               e.credits, m_tdata[M_CRED_LSB +: CRED_OUT_W]);
                        errors++;
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                t.msg_valid = s_tdata[S_VALID_BIT];
                t.msg_low = s_tdata[S_LOW_LSB +: WORD_W];
                t.msg_high = s_tdata[S_HIGH_LSB +: WORD_W];
                t.credit_return = s_tdata[S_RET_BIT];
                t.is_completion = s_tuser[0];
                serialize_tick(t, p);
                link_expect_q.push_back(p);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin : stimulus
        int ret_pct[RAND_PHASES]   = '{0, 90, 5, 30, 0, 60, 10, 100, 2, 40};
        int comp_pct[RAND_PHASES]  = '{5, 20, 50, 10, 0, 30, 90, 10, 20, 50};
        int valid_pct[RAND_PHASES] = '{95, 90, 100, 70, 95, 40, 90, 100, 85, 60};
        int p;
        int k;

        // directed: full count return, offers while busy, completion, cancel
        queue_tick(1'b0, '0, '0, 1'b0, 1'b0);
        queue_tick(1'b1, '1, '1, 1'b0, 1'b1);
        for (k = 0; k < NUM_BEATS; k++) begin
            queue_tick(1'b1, rand_word(), rand_word(), k[0], 1'b0);
        end
        queue_tick(1'b1, '0, '0, 1'b1, 1'b1);
        for (k = 0; k < NUM_BEATS; k++) begin
            queue_tick(1'b0, '1, '1, 1'b1, 1'b0);
        end
        queue_tick(1'b1, {WORD_W/2{2'b01}}, {WORD_W/2{2'b10}}, 1'b0, 1'b0);
        for (k = 0; k < NUM_BEATS; k++) begin
            // return lands on the last beat, so it cancels the spend
            queue_tick(1'b0, '0, '0, 1'b0, k == NUM_BEATS - 1);
        end
        queue_tick(1'b1, {WORD_W/2{2'b10}}, {WORD_W/2{2'b01}}, 1'b0, 1'b0);
        for (k = 0; k < NUM_BEATS; k++) begin
            queue_tick(1'b0, '0, '0, 1'b0, 1'b0);
        end
        queue_tick(1'b0, '0, '0, 1'b0, 1'b1);

        // random phases drain the credits to zero and fill them back up
        for (p = 0; p < RAND_PHASES; p++) begin
            for (k = 0; k < PHASE_TICKS; k++) begin
                queue_tick(chance(valid_pct[p]), rand_word(), rand_word(),
                           chance(comp_pct[p]), chance(ret_pct[p]));
            end
        end

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (tick_pend_q.size() != 0 || s_tvalid || link_expect_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (20) @(posedge aclk);
        @(negedge aclk);
        if (link_expect_q.size() != 0) begin
            $error("%0d result transactions never arrived", link_expect_q.size());
            errors++;
        end
        if (errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

`default_nettype wire

>>> credited_message_serializer.f
+incdir+rtl
rtl/cms_pkg.sv
rtl/credited_message_serializer.sv
rtl/cms_checker.sv
bench/tb.sv
